// ===== hdl/sarbt_pkg.sv =====
// Shared constants, command codes and packed item types of the stereo ring buffer tracker.
// This file has no dependencies; the top level refers to it by scoped names.
`timescale 1ns / 1ps

package sarbt_pkg;

  // Ring geometry.
  localparam int unsigned BufFrames = 2048;
  localparam int unsigned PtrW      = $clog2(BufFrames);
  localparam int unsigned SampleW   = 16;
  localparam int unsigned FrameW    = 2 * SampleW;

  // Window thresholds in frames.
  localparam logic [PtrW-1:0] Half      = PtrW'(BufFrames / 2);
  localparam logic [PtrW-1:0] Quarter   = PtrW'(BufFrames / 4);
  localparam logic [PtrW-1:0] Sixteenth = PtrW'(BufFrames / 16);

  // Tick handling.
  localparam int unsigned TickW        = 32;
  localparam int unsigned ShiftW       = 5;
  localparam int unsigned RemW         = 24;
  localparam logic [ShiftW-1:0] ShiftMax = ShiftW'(RemW);
  localparam logic [ShiftW-1:0] ShiftRst = ShiftW'(13);
  localparam int unsigned BatchW       = 16;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CfgNonblock  = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgTickShift = 1'b1;

  typedef enum logic [1:0] {
    CmdTicks = 2'd0,
    CmdWrite = 2'd1,
    CmdRead  = 2'd2,
    CmdNone  = 2'd3
  } cmd_e;

  // Input payload, highest field first.
  typedef struct packed {
    logic [BatchW-1:0]  batch_frames;
    logic [SampleW-1:0] right_sample;
    logic [SampleW-1:0] left_sample;
    logic [TickW-1:0]   elapsed_ticks;
  } in_data_t;

  typedef struct packed {
    logic batch_first;
    cmd_e cmd;
  } in_user_t;

  localparam int unsigned OutBits = 2 + PtrW + 2 * SampleW;
  localparam int unsigned OutW    = ((OutBits + 7) / 8) * 8;

  typedef struct packed {
    logic [OutW-OutBits-1:0] pad;
    logic [SampleW-1:0]      right_out;
    logic [SampleW-1:0]      left_out;
    logic [PtrW-1:0]         write_avail;
    logic                    resynced;
    logic                    accepted;
  } out_data_t;

endpackage

// ===== hdl/sarbt_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// Standalone; depends on nothing.
`timescale 1ns / 1ps

module sarbt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/stereo_audio_ring_buffer_tracker.sv =====
// Top level of the stereo ring buffer tracker: pointer logic, window check and output stage.
// Depends on sarbt_pkg and on sarbt_ram, which holds the sample frames.
`timescale 1ns / 1ps

// How to use this block:
// Items enter on the slave stream. tuser carries the command and the batch-first flag; tdata
// carries the tick count, both samples and the batch length. Every item gives exactly one
// result on the master stream: the accepted and resynced flags, the free space after the
// item, and for a read command the stereo frame at the play position.
// The result is registered and offered in the cycle after the input transfer. An item can be
// taken every cycle while the output is not stalled: the pointers update in the cycle of the
// transfer, and the frame memory is written or read in that same cycle, so the next item
// already sees the new state. A read right after a write to the same frame returns the new
// frame, since the write lands at the earlier clock edge.
// The output register holds one result. While it is full and the receiver stalls, the input
// stalls too; the transfer that drains the output may take a new item in the same cycle.
// After reset the frame memory is cleared to zero, one frame per cycle, over all 2048 frames;
// tready stays low meanwhile. Configuration writes are taken at any time, including
// during the clear, and should only be issued while no item is in flight.

module stereo_audio_ring_buffer_tracker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Configuration write port.
  input  logic                               cfg_we_i,
  input  logic [sarbt_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [sarbt_pkg::ShiftW-1:0]       cfg_wdata_i,
  // Input stream.
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // tdata, lowest bit up: elapsed_ticks[31:0], left_sample[15:0], right_sample[15:0],
  // batch_frames[15:0].
  input  logic [$bits(sarbt_pkg::in_data_t)-1:0] s_axis_tdata,
  // tuser, lowest bit up: cmd[1:0], batch_first.
  input  logic [$bits(sarbt_pkg::in_user_t)-1:0] s_axis_tuser,
  // Output stream.
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // tdata, lowest bit up: accepted, resynced, write_avail[10:0], left_out[15:0],
  // right_out[15:0], then three zero bits.
  output logic [sarbt_pkg::OutW-1:0]         m_axis_tdata
);

  localparam int unsigned PtrW = sarbt_pkg::PtrW;

  sarbt_pkg::in_data_t in_data;
  sarbt_pkg::in_user_t in_user;
  assign in_data = sarbt_pkg::in_data_t'(s_axis_tdata);
  assign in_user = sarbt_pkg::in_user_t'(s_axis_tuser);

  // Configuration registers.
  logic                          nonblock_q;
  logic [sarbt_pkg::ShiftW-1:0]  tick_shift_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nonblock_q   <= 1'b0;
      tick_shift_q <= sarbt_pkg::ShiftRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sarbt_pkg::CfgNonblock:  nonblock_q   <= cfg_wdata_i[0];
        sarbt_pkg::CfgTickShift: tick_shift_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Clearing pass over the frame memory after reset.
  logic            clearing_q;
  logic [PtrW-1:0] clr_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clearing_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (clr_addr_q == {PtrW{1'b1}}) begin
        clearing_q <= 1'b0;
      end
    end
  end

  // Handshake. The output register is free when empty or being drained this cycle.
  logic out_valid_q;
  logic in_xfer;

  assign s_axis_tready = !clearing_q && (!out_valid_q || m_axis_tready);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  // Pointer and wait state.
  logic [PtrW-1:0]           wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]           play_ptr_q, play_ptr_d;
  logic [sarbt_pkg::RemW-1:0] rem_q, rem_d;
  logic                      waiting_q, waiting_d;

  // Tick accumulation: the play pointer moves by whole sample periods, mod the ring size.
  logic [sarbt_pkg::ShiftW-1:0] shift;
  logic [sarbt_pkg::TickW:0]    tick_total;
  logic [sarbt_pkg::TickW:0]    tick_periods;
  logic [sarbt_pkg::RemW-1:0]   rem_mask;

  assign shift        = (tick_shift_q > sarbt_pkg::ShiftMax) ? sarbt_pkg::ShiftMax
                                                              : tick_shift_q;
  assign tick_total   = {1'b0, in_data.elapsed_ticks} +
                        (sarbt_pkg::TickW + 1)'(rem_q);
  assign tick_periods = tick_total >> shift;
  assign rem_mask     = ~({sarbt_pkg::RemW{1'b1}} << shift);

  // Window check on the current pointers.
  logic [PtrW-1:0] free_cnt;
  logic [PtrW-1:0] used_cnt;
  logic            win_fail;
  logic            do_check;
  logic            resync;
  logic            wait_mid;
  logic            store;
  logic            is_write;

  assign free_cnt = play_ptr_q - wr_ptr_q;
  assign used_cnt = wr_ptr_q - play_ptr_q;
  assign win_fail = (free_cnt < sarbt_pkg::Quarter) ||
                    (used_cnt < sarbt_pkg::Sixteenth) ||
                    (sarbt_pkg::BatchW'(free_cnt) < in_data.batch_frames);
  assign is_write = (in_user.cmd == sarbt_pkg::CmdWrite);
  assign do_check = is_write && in_user.batch_first && !waiting_q && win_fail;
  assign resync   = do_check && nonblock_q;
  // A wait that starts now leaves the pointers untouched, so the release test can use the
  // same distances as the window check.
  assign wait_mid = waiting_q || (do_check && !nonblock_q);

  always_comb begin
    wr_ptr_d   = wr_ptr_q;
    play_ptr_d = play_ptr_q;
    rem_d      = rem_q;
    waiting_d  = waiting_q;
    store      = 1'b0;
    if (in_xfer) begin
      case (in_user.cmd)
        sarbt_pkg::CmdTicks: begin
          rem_d      = tick_total[sarbt_pkg::RemW-1:0] & rem_mask;
          play_ptr_d = play_ptr_q + tick_periods[PtrW-1:0];
        end
        sarbt_pkg::CmdWrite: begin
          waiting_d = wait_mid;
          if (wait_mid && (free_cnt >= sarbt_pkg::Half) &&
              (used_cnt >= sarbt_pkg::Sixteenth)) begin
            waiting_d = 1'b0;
          end
          if (!waiting_d) begin
            store    = 1'b1;
            wr_ptr_d = (resync ? (play_ptr_q + sarbt_pkg::Half) : wr_ptr_q) + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= '0;
      play_ptr_q <= '0;
      rem_q      <= '0;
      waiting_q  <= 1'b0;
    end else begin
      wr_ptr_q   <= wr_ptr_d;
      play_ptr_q <= play_ptr_d;
      rem_q      <= rem_d;
      waiting_q  <= waiting_d;
    end
  end

  // Frame memory: left sample in the low half, right sample in the high half.
  logic                        ram_we;
  logic [PtrW-1:0]             ram_waddr;
  logic [sarbt_pkg::FrameW-1:0] ram_wdata;
  logic                        ram_re;
  logic [sarbt_pkg::FrameW-1:0] ram_rdata;

  assign ram_we    = clearing_q || store;
  assign ram_waddr = clearing_q ? clr_addr_q : (wr_ptr_d - 1'b1);
  assign ram_wdata = clearing_q ? '0 : {in_data.right_sample, in_data.left_sample};
  assign ram_re    = in_xfer && (in_user.cmd == sarbt_pkg::CmdRead);

  sarbt_ram #(
    .WIDTH(sarbt_pkg::FrameW),
    .DEPTH(sarbt_pkg::BufFrames)
  ) u_frame_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(play_ptr_q),
    .rdata_o(ram_rdata)
  );

  // Output register. The read data register of the memory only changes on a new read,
  // which happens only together with a new result, so it holds through a stall.
  logic            acc_q;
  logic            res_q;
  logic            is_read_q;
  logic [PtrW-1:0] avail_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      acc_q     <= store;
      res_q     <= resync;
      is_read_q <= ram_re;
      avail_q   <= play_ptr_d - wr_ptr_d;
    end
  end

  sarbt_pkg::out_data_t out_data;

  always_comb begin
    out_data             = '0;
    out_data.accepted    = acc_q;
    out_data.resynced    = res_q;
    out_data.write_avail = avail_q;
    if (is_read_q) begin
      out_data.left_out  = ram_rdata[sarbt_pkg::SampleW-1:0];
      out_data.right_out = ram_rdata[sarbt_pkg::FrameW-1:sarbt_pkg::SampleW];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data;

endmodule
